### design/fehv_pkg.sv
// Shared constants, types and the log2 fraction table of the frame energy detector.
`default_nettype none

package fehv_pkg;

  localparam int SUM_W         = 41;
  localparam int LOG_BITS      = 6;
  localparam int LOG_SIZE      = 1 << LOG_BITS;
  localparam int REF_EXP       = 30;
  localparam int DB_FACTOR     = 197283;
  localparam int DB_FLOOR      = -24576;
  localparam int MAX_FRAME_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DIV3_MUL      = 43691;
  localparam int DIV3_SHIFT    = 17;

  localparam int CFG_ADDR_W    = 4;
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_KEEP    = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;
  localparam logic [1:0] REG_SQUELCH = 2'd3;

  typedef logic [LOG_SIZE-1:0][15:0] log_tab_t;

  typedef struct packed {
    logic [15:0]        start_thr;
    logic [15:0]        keep_thr;
    logic [15:0]        hold_frames;
    logic signed [15:0] squelch;
  } cfg_t;

  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] v;
    logic [15:0] r;
    for (int m = 0; m < LOG_SIZE; m++) begin
      v = 64'(LOG_SIZE + m) << (REF_EXP - LOG_BITS);
      r = '0;
      for (int i = 0; i < 16; i++) begin
        v = (v * v) >> REF_EXP;
        r = {r[14:0], 1'b0};
        if (v >= 64'h0000_0000_8000_0000) begin
          r[0] = 1'b1;
          v = v >> 1;
        end
      end
      t[m] = r;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

### design/frame_energy_hysteresis_vad.sv
// Top level of the frame energy voice activity detector with hysteresis.
//
// Usage: PCM samples enter on the in_ channel, one item per clock while in_stall
// is low, each with a speech probability and a frame_end flag. The front
// accumulates squared samples and, on the item flagged frame_end, places the
// frame record in a two-entry queue. The back turns each record into one
// result item on the out_ channel: level in Q8.8 dB, Q15 energy, overlong
// flag and the hysteresis speaking decision. Other items give no result.
// Throughput is one sample per cycle while in_stall is low. A frame's time in
// the back part grows with the larger of the sum and count leading zeros, set
// by the one-bit-per-cycle normalizer, and is shorter at 0 dB. in_stall rises
// only while the queue holds two unprocessed frames. When out_stall is high
// with a result valid, the result register holds and the back part waits to
// write the next one, while the front keeps accepting samples until the queue
// is full. Reset sets the accumulator to one, clears the hysteresis state and
// the queue, and loads the register defaults. The user must write registers
// through the APB port only while the block is idle; the block does not enforce it.
`default_nettype none

module frame_energy_hysteresis_vad
  import fehv_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [15:0]    in_sample,
  input  wire logic signed [16:0]    in_speech_prob,
  input  wire logic                  in_frame_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_speaking,
  output logic [15:0]                out_energy_level,
  output logic signed [15:0]         out_level_db,
  output logic                       out_overlong,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int REC_W = SUM_W + CNT_W + 18;

  cfg_t             cfg_r, cfg_nxt;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic             q_push, q_pop, q_full, q_empty;
  logic [REC_W-1:0] q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START:   cfg_nxt.start_thr   = pwdata[15:0];
        REG_KEEP:    cfg_nxt.keep_thr    = pwdata[15:0];
        REG_HOLD:    cfg_nxt.hold_frames = pwdata[15:0];
        REG_SQUELCH: cfg_nxt.squelch     = $signed(pwdata[15:0]);
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START:   prdata = {16'd0, cfg_r.start_thr};
      REG_KEEP:    prdata = {16'd0, cfg_r.keep_thr};
      REG_HOLD:    prdata = {16'd0, cfg_r.hold_frames};
      REG_SQUELCH: prdata = {16'd0, cfg_r.squelch};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr   <= 16'd16384;
      cfg_r.keep_thr    <= 16'd8192;
      cfg_r.hold_frames <= 16'd0;
      cfg_r.squelch     <= -16'sd16640;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fehv_front #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_speech_prob (in_speech_prob),
    .in_frame_end   (in_frame_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  fehv_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  fehv_back #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_speaking     (out_speaking),
    .out_energy_level (out_energy_level),
    .out_level_db     (out_level_db),
    .out_overlong     (out_overlong)
  );

endmodule

`default_nettype wire

### design/fehv_queue.sv
// Small first-in first-out queue of finished frame records.
`default_nettype none

module fehv_queue
  import fehv_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/fehv_front.sv
// Sample accumulator that sums squares per frame and queues a record at frame end.
`default_nettype none

module fehv_front
  import fehv_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_sample,
  input  wire logic signed [16:0] in_speech_prob,
  input  wire logic               in_frame_end,
  input  wire logic               q_full,
  output logic                    q_push,
  output logic [SUM_W+CNT_W+17:0] q_data
);

  logic             accept;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      square;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic             add_ok;
  logic [SUM_W-1:0] rec_sum;
  logic [CNT_W-1:0] rec_cnt;
  logic             rec_ovf;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign square   = 32'(in_sample) * 32'(in_sample);
  assign sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(square);
  assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign add_ok   = (cnt_r < CNT_W'(MAX_FRAME));
  assign rec_sum  = add_ok ? sum_sat : sum_r;
  assign rec_cnt  = add_ok ? cnt_r + 1'b1 : cnt_r;
  assign rec_ovf  = ovf_r || !add_ok;
  assign q_push   = accept && in_frame_end;
  assign q_data   = {rec_sum, rec_cnt, rec_ovf, in_speech_prob};

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_frame_end) begin
        sum_nxt = SUM_W'(1);
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        sum_nxt = rec_sum;
        cnt_nxt = rec_cnt;
        ovf_nxt = rec_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= SUM_W'(1);
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

### design/fehv_back.sv
// Frame-end sequencer: level in dB, energy, score, hysteresis decision and result register.
`default_nettype none

module fehv_back
  import fehv_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    q_empty,
  input  wire logic [SUM_W+CNT_W+17:0] q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_speaking,
  output logic [15:0]                  out_energy_level,
  output logic signed [15:0]           out_level_db,
  output logic                         out_overlong
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DB   = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam int ZS_W     = $clog2(SUM_W);
  localparam int ZC_W     = $clog2(CNT_W + 1);
  localparam int EXP_BASE = SUM_W - CNT_W - REF_EXP;
  localparam logic signed [18:0] DB_MUL_C = 19'(DB_FACTOR);
  localparam logic signed [20:0] FLOOR_C  = 21'(DB_FLOOR);

  logic [2:0]             state_r, state_nxt;
  logic [SUM_W-1:0]       ns_r, ns_nxt;
  logic [CNT_W-1:0]       nc_r, nc_nxt;
  logic [ZS_W-1:0]        zs_r, zs_nxt;
  logic [ZC_W-1:0]        zc_r, zc_nxt;
  logic signed [16:0]     prob_r, prob_nxt;
  logic                   ovf_r, ovf_nxt;
  logic signed [25:0]     d_r, d_nxt;
  logic signed [44:0]     prod_r, prod_nxt;
  logic signed [15:0]     db_r, db_nxt;
  logic [16:0]            x_r, x_nxt;
  logic [33:0]            qp_r, qp_nxt;
  logic                   act_r, act_nxt;
  logic [15:0]            hold_r, hold_nxt;
  logic                   ov_r, ov_nxt;
  logic                   sp_r, sp_nxt;
  logic [15:0]            en_r, en_nxt;
  logic signed [15:0]     lv_r, lv_nxt;
  logic                   ol_r, ol_nxt;

  logic                   out_free;
  logic [LOG_BITS-1:0]    ms, mc;
  logic [CNT_W+LOG_BITS-1:0] nc_ext;
  logic [9:0]             exp10;
  logic signed [20:0]     db_full;
  logic [15:0]            db_neg;
  logic [16:0]            quot;
  logic [15:0]            energy;
  logic signed [17:0]     score;
  logic [16:0]            start_eff, keep_eff;
  logic                   detected;

  assign out_free         = !ov_r || !out_stall;
  assign out_valid        = ov_r;
  assign out_speaking     = sp_r;
  assign out_energy_level = en_r;
  assign out_level_db     = lv_r;
  assign out_overlong     = ol_r;

  assign ms      = ns_r[SUM_W-2 -: LOG_BITS];
  assign nc_ext  = {nc_r, {LOG_BITS{1'b0}}};
  assign mc      = nc_ext[CNT_W+LOG_BITS-2 -: LOG_BITS];
  assign exp10   = 10'(EXP_BASE) + 10'(zc_r) - 10'(zs_r);
  assign db_full = 21'(prod_r >>> 24);
  assign db_neg  = 16'(-db_r);
  assign quot    = qp_r[33:DIV3_SHIFT];
  assign energy  = 16'(17'd32768 - quot);

  always_comb begin
    start_eff = (cfg.start_thr > 16'd32768) ? 17'd32768 : {1'b0, cfg.start_thr};
    keep_eff  = ({1'b0, cfg.keep_thr} > start_eff) ? start_eff : {1'b0, cfg.keep_thr};
    if (db_r >= cfg.squelch) begin
      score = prob_r[16] ? $signed({2'b00, energy}) : 18'(prob_r);
    end else begin
      score = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ns_nxt    = ns_r;
    nc_nxt    = nc_r;
    zs_nxt    = zs_r;
    zc_nxt    = zc_r;
    prob_nxt  = prob_r;
    ovf_nxt   = ovf_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    db_nxt    = db_r;
    x_nxt     = x_r;
    qp_nxt    = qp_r;
    act_nxt   = act_r;
    hold_nxt  = hold_r;
    ov_nxt    = ov_r && out_stall;
    sp_nxt    = sp_r;
    en_nxt    = en_r;
    lv_nxt    = lv_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    detected  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ns_nxt    = q_data[SUM_W+CNT_W+17:CNT_W+18];
          nc_nxt    = q_data[CNT_W+17:18];
          ovf_nxt   = q_data[17];
          prob_nxt  = $signed(q_data[16:0]);
          zs_nxt    = '0;
          zc_nxt    = '0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!ns_r[SUM_W-1]) begin
          ns_nxt = {ns_r[SUM_W-2:0], 1'b0};
          zs_nxt = zs_r + 1'b1;
        end
        if (!nc_r[CNT_W-1]) begin
          nc_nxt = nc_r << 1;
          zc_nxt = zc_r + 1'b1;
        end
        if (ns_r[SUM_W-1] && nc_r[CNT_W-1]) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        d_nxt = $signed({exp10, 16'h0000}) + $signed({10'd0, LOG_TAB[ms]})
              - $signed({10'd0, LOG_TAB[mc]});
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = d_r * DB_MUL_C;
        state_nxt = ST_DB;
      end
      ST_DB: begin
        if (db_full < FLOOR_C) begin
          db_nxt = 16'(DB_FLOOR);
        end else if (db_full > 21'sd0) begin
          db_nxt = '0;
        end else begin
          db_nxt = 16'(db_full);
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        x_nxt     = {db_neg[14:0], 2'b00};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (qp_r == '0 && x_r != '0) begin
          qp_nxt = 34'(x_r) * 34'(DIV3_MUL);
        end else if (out_free) begin
          if (act_r) begin
            if (score >= $signed({1'b0, keep_eff})) begin
              detected = 1'b1;
              hold_nxt = cfg.hold_frames;
            end else if (hold_r != '0) begin
              detected = 1'b1;
              hold_nxt = hold_r - 1'b1;
            end
          end else if (score >= $signed({1'b0, start_eff})) begin
            detected = 1'b1;
            hold_nxt = cfg.hold_frames;
          end
          act_nxt   = detected;
          ov_nxt    = 1'b1;
          sp_nxt    = detected;
          en_nxt    = energy;
          lv_nxt    = db_r;
          ol_nxt    = ovf_r;
          qp_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= 1'b0;
      hold_r  <= '0;
      ov_r    <= 1'b0;
      qp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      hold_r  <= hold_nxt;
      ov_r    <= ov_nxt;
      qp_r    <= qp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ns_r   <= ns_nxt;
    nc_r   <= nc_nxt;
    zs_r   <= zs_nxt;
    zc_r   <= zc_nxt;
    prob_r <= prob_nxt;
    ovf_r  <= ovf_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    db_r   <= db_nxt;
    x_r    <= x_nxt;
    sp_r   <= sp_nxt;
    en_r   <= en_nxt;
    lv_r   <= lv_nxt;
    ol_r   <= ol_nxt;
  end

  // A popped record must land in the normalizer.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE) && !q_empty)
    else $error("record popped outside idle");

  // The frame sum and sample count are never zero, so normalization always ends.
  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM) |-> (ns_r != '0) && (nc_r != '0))
    else $error("zero operand in normalizer");

  // A delivered level stays within the floor and full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (lv_r <= 16'sd0) && (lv_r >= 16'(DB_FLOOR)) && (en_r <= 16'd32768))
    else $error("result out of range");

  // The hold count only moves when a result is written.
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(ov_nxt && !ov_r || ov_nxt && !out_stall) |-> $stable(hold_r))
    else $error("hold count changed without a result");

endmodule

`default_nettype wire
